@@ hw/rtl/abps_pkg.sv @@
// shared types and constants for the active-backup port selector
// entry layout, event kinds, best-port tracker control and stream widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package abps_pkg;

  // default table depth
  localparam int ABPS_MAX_PORTS = 16;

  // field widths
  localparam int KIND_W  = 2;
  localparam int PORT_W  = 4;
  localparam int PRIO_W  = 16;
  localparam int SPEED_W = 20;

  // stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = KIND_W;
  localparam int OUT_TDATA_W = 8;

  // event kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LINK   = 2'd2,
    KIND_PRIO   = 2'd3
  } kind_t;

  // one table entry, 40 bits
  typedef struct packed {
    logic                      present;
    logic                      link_up;
    logic signed [PRIO_W-1:0]  prio;
    logic [SPEED_W-1:0]        speed;
    logic                      duplex;
    logic                      sticky;
  } port_entry_t;

  // control of the best-port tracker
  typedef struct packed {
    logic start;
    logic offer;
  } best_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/active_backup_port_selector_core.sv @@
// top level of the active-backup port selector
// port table memory, event update, re-evaluation sequencer and result register
// depends on abps_pkg and abps_best
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tuser kind, in_tdata port event fields
//  out_    | out | out_tvalid/out_tready| out_tdata active_valid, act_port, changed
//
// one event is handled in steps: read and write back the event entry, read the
// active entry, then walk every entry through the single read port of the table
// memory, one entry per cycle, then decide
// reset is synchronous, active low; the table reads as all absent after reset
// through per-entry valid bits
// a result waiting in the output register does not block the next event; only
// the final step waits for the output register to free up
`timescale 1ns / 1ps
`default_nettype none

module active_backup_port_selector_core #(
  parameter int MAX_PORTS = abps_pkg::ABPS_MAX_PORTS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // lsb up: port[3:0], link_up[4], priority_req[20:5], speed_mbps[40:21],
  // full_duplex[41], sticky[42], zero pad[47:43]
  input  wire logic [abps_pkg::IN_TDATA_W-1:0] in_tdata,
  // lsb up: kind[1:0]
  input  wire logic [abps_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // lsb up: active_valid[0], act_port[4:1], changed[5], zero pad[7:6]
  output logic [abps_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import abps_pkg::*;

  localparam int IDX_W = $clog2(MAX_PORTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PORTS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RMW   = 6'b000010,
    S_ACTRD = 6'b000100,
    S_ACTEV = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // input field unpacking
  logic [PORT_W-1:0]        in_port;
  logic                     in_port_ok;
  assign in_port    = in_tdata[3:0];
  assign in_port_ok = (32'(in_port) < MAX_PORTS);

  // captured event
  kind_t                    kind_r;
  logic [IDX_W-1:0]         ev_idx_r;
  logic                     ev_ok_r;
  logic                     ev_link_r;
  logic signed [PRIO_W-1:0] ev_prio_r;
  logic [SPEED_W-1:0]       ev_speed_r;
  logic                     ev_dup_r;
  logic                     ev_sticky_r;

  // table memory and valid bits
  port_entry_t              mem [MAX_PORTS];
  logic [MAX_PORTS-1:0]     vld_r;
  port_entry_t              rdata_r;
  logic                     rd_vld_r;
  logic [IDX_W-1:0]         rd_addr;
  logic                     mem_we;
  port_entry_t              wdata;
  port_entry_t              entry;

  // active port and walk state
  logic                     act_vld_r, act_vld_nxt;
  logic [IDX_W-1:0]         act_idx_r, act_idx_nxt;
  logic                     act_sticky_r;
  logic                     chg_r;
  logic [IDX_W-1:0]         cnt_r;
  logic                     act_up;
  logic                     take;
  logic                     chg_nxt;
  logic                     out_free;

  // result register
  logic                     out_vld_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;

  // best tracker
  best_ctl_t                bctl;
  logic [IDX_W-1:0]         cand_idx;
  logic                     have;
  logic [IDX_W-1:0]         best_idx;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_vld_r || out_tready;

  // a never-written entry reads as absent and zero
  assign entry = rd_vld_r ? rdata_r : '0;

  // read address per step
  always_comb begin
    rd_addr = '0;
    unique case (state_r)
      S_IDLE:  rd_addr = in_port_ok ? IDX_W'(in_port) : '0;
      S_ACTRD: rd_addr = act_idx_r;
      S_SCAN:  rd_addr = (cnt_r == LAST_IDX) ? '0 : cnt_r + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  // updated event entry
  always_comb begin
    wdata = entry;
    case (kind_r)
      KIND_ADD: begin
        wdata.present = 1'b1;
        wdata.link_up = ev_link_r;
        wdata.prio    = ev_prio_r;
        wdata.speed   = ev_speed_r;
        wdata.duplex  = ev_dup_r;
        wdata.sticky  = ev_sticky_r;
      end
      KIND_REMOVE: wdata = '0;
      KIND_LINK: begin
        if (entry.present) begin
          wdata.link_up = ev_link_r;
          wdata.speed   = ev_speed_r;
          wdata.duplex  = ev_dup_r;
        end
      end
      default: begin
        if (entry.present) begin
          wdata.prio = ev_prio_r;
        end
      end
    endcase
  end

  assign mem_we = (state_r == S_RMW) && ev_ok_r;

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ev_idx_r] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[ev_idx_r] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // event capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r      <= kind_t'(in_tuser[1:0]);
      ev_idx_r    <= in_port_ok ? IDX_W'(in_port) : '0;
      ev_ok_r     <= in_port_ok;
      ev_link_r   <= in_tdata[4];
      ev_prio_r   <= in_tdata[20:5];
      ev_speed_r  <= in_tdata[40:21];
      ev_dup_r    <= in_tdata[41];
      ev_sticky_r <= in_tdata[42];
    end
  end

  // best tracker control
  assign act_up   = entry.present & entry.link_up;
  assign cand_idx = (state_r == S_ACTEV) ? act_idx_r : cnt_r;
  always_comb begin
    bctl.start = (state_r == S_ACTRD);
    bctl.offer = ((state_r == S_ACTEV) && act_vld_r && act_up) || (state_r == S_SCAN);
  end

  abps_best #(
    .IDX_W (IDX_W)
  ) u_best (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (bctl),
    .cand_idx (cand_idx),
    .cand     (entry),
    .have     (have),
    .best_idx (best_idx)
  );

  // final decision: takeover unless a valid sticky active port holds on
  assign take    = have && !(act_vld_r && (best_idx == act_idx_r)) &&
                   (!act_vld_r || !act_sticky_r);
  assign chg_nxt = chg_r | take;
  always_comb begin
    act_vld_nxt = act_vld_r;
    act_idx_nxt = act_idx_r;
    if (take) begin
      act_vld_nxt = 1'b1;
      act_idx_nxt = best_idx;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_RMW;
      S_RMW:   state_nxt = S_ACTRD;
      S_ACTRD: state_nxt = S_ACTEV;
      S_ACTEV: state_nxt = S_SCAN;
      S_SCAN:  if (cnt_r == LAST_IDX) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      act_vld_r <= 1'b0;
      act_idx_r <= '0;
      chg_r     <= 1'b0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // output valid: set by the decision step, cleared when the item is taken
      if ((state_r == S_DONE) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_RMW: chg_r <= 1'b0;
        S_ACTEV: begin
          cnt_r <= '0;
          // active port gone or down
          if (act_vld_r && !act_up) begin
            act_vld_r <= 1'b0;
            act_idx_r <= '0;
            chg_r     <= 1'b1;
          end
        end
        S_SCAN: cnt_r <= cnt_r + 1'b1;
        S_DONE: begin
          if (out_free) begin
            act_vld_r <= act_vld_nxt;
            act_idx_r <= act_idx_nxt;
          end
        end
        default: ;
      endcase
    end
  end

  // sticky flag of the active entry after the update
  always_ff @(posedge clk) begin
    if (state_r == S_ACTEV) begin
      act_sticky_r <= entry.sticky;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_data_r <= {2'b00, chg_nxt, 4'(act_idx_nxt), act_vld_nxt};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // no active port means index zero
  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !act_vld_r |-> (act_idx_r == '0))
    else $error("active index not zero while no port is active");

  // the table is written only in the update step
  a_we_step: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_RMW))
    else $error("table write outside the update step");

  // an unchanged result keeps the active port
  a_nochg: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_free && !chg_nxt) |=>
      ((act_vld_r == $past(act_vld_r)) && (act_idx_r == $past(act_idx_r))))
    else $error("active port moved without a change flag");

  // a result is only loaded when the output register is free
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready && (state_r == S_DONE)) |=> (state_r == S_DONE))
    else $error("decision step left while the result register was full");

endmodule

`default_nettype wire

@@ hw/rtl/abps_best.sv @@
// best-so-far tracker for the port re-evaluation walk
// applies the selection rule to one offered entry per cycle
// depends on abps_pkg
`timescale 1ns / 1ps
`default_nettype none

module abps_best #(
  parameter int IDX_W = $clog2(abps_pkg::ABPS_MAX_PORTS)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire abps_pkg::best_ctl_t     ctl,
  input  wire logic [IDX_W-1:0]        cand_idx,
  input  wire abps_pkg::port_entry_t   cand,
  output logic                         have,
  output logic [IDX_W-1:0]             best_idx
);
  import abps_pkg::*;

  logic                     have_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [PRIO_W-1:0] prio_r;
  logic [SPEED_W-1:0]       speed_r;
  logic                     dup_r;
  logic                     cand_up;
  logic                     better;
  logic                     take;

  // candidate must be up and not already the best
  assign cand_up = cand.present & cand.link_up;
  // priority higher, or speed higher, or same speed with better duplex
  assign better  = ($signed(cand.prio) > $signed(prio_r)) || (cand.speed > speed_r) ||
                   ((cand.speed == speed_r) && (cand.duplex > dup_r));
  assign take    = ctl.offer && cand_up && !(have_r && (idx_r == cand_idx)) &&
                   (!have_r || better);

  // tracker valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (ctl.start) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r <= 1'b1;
    end
  end

  // best entry payload
  always_ff @(posedge clk) begin
    if (take) begin
      idx_r   <= cand_idx;
      prio_r  <= cand.prio;
      speed_r <= cand.speed;
      dup_r   <= cand.duplex;
    end
  end

  assign have     = have_r;
  assign best_idx = idx_r;

endmodule

`default_nettype wire

@@ test/failover_checker.sv @@
// failover checker: watches the event and selection streams of the port selector,
// keeps its own member table and active port, and compares every selection item
// depends on abps_pkg
`timescale 1ns / 1ps

module failover_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,
  output int               error_count,
  output int               pending,
  output int               checked,
  output int               switches
);

  import abps_pkg::*;

  // one selection item as it leaves the block
  typedef struct packed {
    logic       changed;
    logic [3:0] port;
    logic       valid;
  } selection_t;

  selection_t  expected_selections[$];
  port_entry_t member_table[16];
  logic        act_valid;
  logic [3:0]  act_idx;
  int          errors;
  int          seen;
  int          moves;

  // apply one event to the member table, then rerun the failover decision
  function automatic selection_t predict_failover(kind_t kind, logic [3:0] idx, logic up,
                                                  logic signed [15:0] prio, logic [19:0] spd,
                                                  logic dup, logic stk);
    selection_t  res;
    port_entry_t c;
    port_entry_t b;
    logic        have;
    logic        chg;
    logic [3:0]  best;
    logic [3:0]  cand;
    have = 1'b0;
    chg  = 1'b0;
    best = 4'd0;
    case (kind)
      KIND_ADD: begin
        member_table[idx].present = 1'b1;
        member_table[idx].link_up = up;
        member_table[idx].prio    = prio;
        member_table[idx].speed   = spd;
        member_table[idx].duplex  = dup;
        member_table[idx].sticky  = stk;
      end
      KIND_REMOVE: member_table[idx] = '0;
      KIND_LINK: begin
        if (member_table[idx].present) begin
          member_table[idx].link_up = up;
          member_table[idx].speed   = spd;
          member_table[idx].duplex  = dup;
        end
      end
      default: begin
        if (member_table[idx].present) member_table[idx].prio = prio;
      end
    endcase

    // drop an active port that is gone or down
    if (act_valid && !(member_table[act_idx].present && member_table[act_idx].link_up)) begin
      act_valid = 1'b0;
      act_idx   = 4'd0;
      chg       = 1'b1;
    end

    // active port first, then every port in index order
    for (int k = -1; k < 16; k++) begin
      cand = (k < 0) ? act_idx : 4'(k);
      if ((k >= 0 || act_valid) && member_table[cand].present && member_table[cand].link_up &&
          !(have && best == cand)) begin
        c = member_table[cand];
        b = member_table[best];
        if (!have) begin
          have = 1'b1;
          best = cand;
        end else if ($signed(c.prio) > $signed(b.prio) || c.speed > b.speed ||
                     (c.speed == b.speed && c.duplex > b.duplex)) begin
          best = cand;
        end
      end
    end

    // a sticky active port holds against a better one
    if (have && !(act_valid && best == act_idx)) begin
      if (!act_valid || !member_table[act_idx].sticky) begin
        act_valid = 1'b1;
        act_idx   = best;
        chg       = 1'b1;
      end
    end

    res.valid   = act_valid;
    res.port    = act_valid ? act_idx : 4'd0;
    res.changed = chg;
    return res;
  endfunction

  // predict on each accepted event, compare on each accepted selection
  always @(posedge clk) begin
    selection_t exp_sel;
    selection_t got;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) member_table[i] = '0;
      act_valid = 1'b0;
      act_idx   = 4'd0;
      expected_selections.delete();
      errors = 0;
      seen   = 0;
      moves  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        exp_sel = predict_failover(kind_t'(in_tuser), in_tdata[3:0], in_tdata[4],
                                   in_tdata[20:5], in_tdata[40:21], in_tdata[41], in_tdata[42]);
        expected_selections.push_back(exp_sel);
      end
      if (out_tvalid && out_tready) begin
        got  = out_tdata[5:0];
        seen = seen + 1;
        if (expected_selections.size() == 0) begin
          if (errors < 10)
            $display("%0t: selection item with nothing expected: valid=%b port=%0d changed=%b",
                     $realtime, got.valid, got.port, got.changed);
          errors = errors + 1;
        end else begin
          exp_sel = expected_selections.pop_front();
          if (got.valid !== exp_sel.valid || got.port !== exp_sel.port ||
              got.changed !== exp_sel.changed) begin
            if (errors < 10)
              $display("%0t: selection mismatch: expected valid=%b port=%0d changed=%b, got valid=%b port=%0d changed=%b",
                       $realtime, exp_sel.valid, exp_sel.port, exp_sel.changed,
                       got.valid, got.port, got.changed);
            errors = errors + 1;
          end
          if (exp_sel.changed) moves = moves + 1;
        end
      end
    end
    error_count <= errors;
    pending     <= expected_selections.size();
    checked     <= seen;
    switches    <= moves;
  end

endmodule

@@ test/active_backup_port_selector_core_tb.sv @@
// testbench top for the active-backup port selector: clock, reset, event stimulus,
// random stalls on both streams and the final verdict
// depends on abps_pkg, active_backup_port_selector_core and failover_checker
`timescale 1ns / 1ps

module active_backup_port_selector_core_tb;

  import abps_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [15:0] joined;
  bit          send_idle_on;
  bit          recv_idle_on;
  int          errors;
  int          pending;
  int          checked;
  int          switches;
  int          sent;

  active_backup_port_selector_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  failover_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .error_count (errors),
    .pending     (pending),
    .checked     (checked),
    .switches    (switches)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAIL active_backup_port_selector_core");
    $finish;
  end

  // selection stream stalls
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (recv_idle_on && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  // drive one event item and wait for it to be taken; called at a falling edge
  task automatic send_event(kind_t kind, logic [3:0] idx, logic up, logic signed [15:0] prio,
                            logic [19:0] spd, logic dup, logic stk);
    int gap;
    if (send_idle_on && $urandom_range(0, 2) == 0) begin
      in_tvalid = 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    in_tuser  = kind;
    in_tdata  = {5'b0, stk, dup, spd, prio, up, idx};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (kind == KIND_ADD) joined[idx] = 1'b1;
    if (kind == KIND_REMOVE) joined[idx] = 1'b0;
    sent = sent + 1;
  endtask

  // random event, mostly on member ports and from a few shared speeds and priorities
  task automatic random_event();
    kind_t              kind;
    logic [3:0]         idx;
    logic signed [15:0] prio;
    logic [19:0]        spd;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 35) kind = KIND_ADD;
    else if (r < 65) kind = KIND_LINK;
    else if (r < 80) kind = KIND_PRIO;
    else kind = KIND_REMOVE;

    if (kind != KIND_ADD && joined != 16'd0 && $urandom_range(0, 9) < 8) begin
      do idx = 4'($urandom_range(0, 15)); while (!joined[idx]);
    end else if ($urandom_range(0, 3) == 0) begin
      idx = 4'($urandom_range(0, 15));
    end else begin
      idx = 4'($urandom_range(0, 5));
    end

    case ($urandom_range(0, 5))
      0:       prio = 16'sh8000;
      1:       prio = 16'sh7FFF;
      2:       prio = 16'sd0;
      3:       prio = -16'sd1;
      default: prio = 16'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       spd = 20'd0;
      1:       spd = 20'd1000000;
      2:       spd = 20'd1000;
      3:       spd = 20'd10000;
      default: spd = 20'($urandom_range(0, 1000000));
    endcase

    send_event(kind, idx, $urandom_range(0, 3) != 0, prio, spd, 1'($urandom_range(0, 1)),
               $urandom_range(0, 3) == 0);
  endtask

  // stimulus and verdict
  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = KIND_ADD;
    joined       = '0;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    sent         = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // events on absent ports leave the table alone
    send_event(KIND_LINK,   4'd3,  1'b1, 16'sd5,     20'd100,     1'b1, 1'b0);
    send_event(KIND_REMOVE, 4'd7,  1'b0, 16'sd0,     20'd0,       1'b0, 1'b0);
    send_event(KIND_PRIO,   4'd2,  1'b0, 16'sh7FFF,  20'd0,       1'b0, 1'b0);
    // first up port becomes active, higher priority takes over
    send_event(KIND_ADD,    4'd0,  1'b1, 16'sd0,     20'd1000,    1'b1, 1'b0);
    send_event(KIND_ADD,    4'd15, 1'b1, 16'sh7FFF,  20'd0,       1'b0, 1'b0);
    // lower priority but higher speed: the higher-priority port stays active
    send_event(KIND_ADD,    4'd5,  1'b1, 16'sh8000,  20'd1000000, 1'b1, 1'b0);
    // equal speed with either duplex: the active port stays
    send_event(KIND_ADD,    4'd9,  1'b1, 16'sh8000,  20'd1000000, 1'b0, 1'b1);
    send_event(KIND_ADD,    4'd10, 1'b1, 16'sh8000,  20'd1000000, 1'b1, 1'b0);
    // a backup link drops, then the active port loses its priority and is replaced
    send_event(KIND_LINK,   4'd5,  1'b0, 16'sd0,     20'd1000000, 1'b1, 1'b0);
    send_event(KIND_PRIO,   4'd15, 1'b0, 16'sh8000,  20'd0,       1'b0, 1'b0);
    // sticky port added without taking over, a higher-priority port takes over, link changes
    send_event(KIND_ADD,    4'd1,  1'b1, 16'sh7FFF,  20'd500000,  1'b1, 1'b1);
    send_event(KIND_ADD,    4'd3,  1'b1, 16'sh7FFF,  20'd1000000, 1'b1, 1'b0);
    send_event(KIND_PRIO,   4'd3,  1'b0, 16'sh7FFF,  20'd0,       1'b0, 1'b0);
    send_event(KIND_LINK,   4'd1,  1'b0, 16'sd0,     20'd500000,  1'b1, 1'b0);
    send_event(KIND_LINK,   4'd1,  1'b1, 16'sd0,     20'd1000000, 1'b1, 1'b0);
    // removal of the active port, down port added, re-add over a member
    send_event(KIND_REMOVE, 4'd3,  1'b0, 16'sd0,     20'd0,       1'b0, 1'b0);
    send_event(KIND_ADD,    4'd4,  1'b0, -16'sd1,    20'd999999,  1'b1, 1'b1);
    send_event(KIND_ADD,    4'd1,  1'b1, 16'sh8000,  20'd0,       1'b0, 1'b0);
    send_event(KIND_REMOVE, 4'd12, 1'b0, 16'sd0,     20'd0,       1'b0, 1'b0);
    // drain the table so nothing is active
    send_event(KIND_REMOVE, 4'd0,  1'b0, 16'sd0,     20'd0,       1'b0, 1'b0);
    send_event(KIND_REMOVE, 4'd1,  1'b0, 16'sd0,     20'd0,       1'b0, 1'b0);
    send_event(KIND_REMOVE, 4'd9,  1'b0, 16'sd0,     20'd0,       1'b0, 1'b0);
    send_event(KIND_REMOVE, 4'd10, 1'b0, 16'sd0,     20'd0,       1'b0, 1'b0);
    send_event(KIND_REMOVE, 4'd15, 1'b0, 16'sd0,     20'd0,       1'b0, 1'b0);

    // random phases, with and without stalls
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    repeat (300) random_event();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    repeat (150) random_event();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    repeat (100) random_event();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    repeat (50) random_event();
    in_tvalid = 1'b0;

    // drain the last selections
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);

    $display("sent %0d port events (adds, removals, link and priority changes)", sent);
    $display("checked %0d selection items, %0d of them moved the active port",
             checked, switches);
    if (errors == 0) begin
      $display("PASS active_backup_port_selector_core");
    end else begin
      $display("FAIL active_backup_port_selector_core");
    end
    $finish;
  end

endmodule
